// File: rtl/wss_pkg.sv
package wss_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_BITS   = $clog2(MAX_DEPTH);
    localparam int COUNT_BITS  = $clog2(MAX_DEPTH + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS;
    localparam int DIV_STEPS   = SAMPLE_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(MAX_DEPTH);

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SUM_BITS-1:0] a;
        logic [SUM_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] result;
        logic                borrow;
    } alu_rsp_t;

endpackage

// File: rtl/windowed_sample_statistics.sv
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------------
// in        | in_valid, in_stall  | sample_duration
// out       | out_valid, out_stall| sample_count, average_duration, minimum_duration,
//           |                     | maximum_duration
// config    | apb psel/penable    | window_length at byte address 0
//
// one transaction is paced by the single add/subtract unit: a subtract, an add, then two
// compares per held sample (count = samples held after it, up to 64) and 32 divide steps
// in_stall is high from acceptance until the result is taken on the output
// rst_n is asynchronous; the store has no reset and no value read from it is used before being written
// a result held under out_stall keeps its payload, unless window_length is written, and blocks the next input
module windowed_sample_statistics (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wss_pkg::SAMPLE_BITS-1:0]   sample_duration,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wss_pkg::COUNT_BITS-1:0]    sample_count,
    output logic [wss_pkg::SAMPLE_BITS-1:0]   average_duration,
    output logic [wss_pkg::SAMPLE_BITS-1:0]   minimum_duration,
    output logic [wss_pkg::SAMPLE_BITS-1:0]   maximum_duration,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wss_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [wss_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [wss_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import wss_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SUB     = 3'd1;
    localparam logic [2:0] S_ADD     = 3'd2;
    localparam logic [2:0] S_SCAN_LO = 3'd3;
    localparam logic [2:0] S_SCAN_HI = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    localparam logic REG_WINDOW_LENGTH = 1'b0;

    localparam int HI_BITS = SUM_BITS - SAMPLE_BITS;

    logic [2:0]             state_reg,  state_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [ADDR_BITS-1:0]   pos_reg,    pos_next;
    logic                   full_reg,   full_next;
    logic [ADDR_BITS-1:0]   wpos_reg,   wpos_next;
    logic [COUNT_BITS-1:0]  held_reg,   held_next;
    logic [SUM_BITS-1:0]    sum_reg,    sum_next;
    logic [ADDR_BITS-1:0]   idx_reg,    idx_next;
    logic [SAMPLE_BITS-1:0] lo_reg,     lo_next;
    logic [SAMPLE_BITS-1:0] hi_reg,     hi_next;
    logic [COUNT_BITS-1:0]  rem_reg,    rem_next;
    logic [SAMPLE_BITS-1:0] dq_reg,     dq_next;
    logic [STEP_BITS-1:0]   cnt_reg,    cnt_next;
    logic [COUNT_BITS-1:0]  wl_reg,     wl_next;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   wr_en;

    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    logic [COUNT_BITS-1:0]  eff_len;
    logic [ADDR_BITS-1:0]   start_pos;
    logic [COUNT_BITS:0]    div_shift;
    logic                   cfg_write;
    logic                   scan_last;

    wss_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // window length zero acts as one, above the depth saturates
    always_comb
    begin
        if (wl_reg == '0)
        begin
            eff_len = COUNT_BITS'(1);
        end
        else if (wl_reg > COUNT_BITS'(MAX_DEPTH))
        begin
            eff_len = COUNT_BITS'(MAX_DEPTH);
        end
        else
        begin
            eff_len = wl_reg;
        end
    end

    assign start_pos = ({1'b0, wpos_reg} >= eff_len) ? '0 : wpos_reg;
    assign div_shift = {rem_reg, dq_reg[SAMPLE_BITS-1]};
    assign scan_last = (({1'b0, idx_reg} + COUNT_BITS'(1)) == held_reg);
    assign cfg_write = psel && penable && pwrite && pready;

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = (state_reg == S_OUT);
    assign sample_count     = held_reg;
    assign average_duration = dq_reg;
    assign minimum_duration = lo_reg;
    assign maximum_duration = hi_reg;
    assign pready           = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_WINDOW_LENGTH)
        begin
            prdata = {{(PDATA_BITS-COUNT_BITS){1'b0}}, wl_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // shared unit operands per sequencer step
    always_comb
    begin
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            S_SUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = sum_reg;
                alu_req.b  = {{HI_BITS{1'b0}}, rd_data_reg};
            end
            S_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = sum_reg;
                alu_req.b  = {{HI_BITS{1'b0}}, sample_reg};
            end
            S_SCAN_LO:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{HI_BITS{1'b0}}, rd_data_reg};
                alu_req.b  = {{HI_BITS{1'b0}}, lo_reg};
            end
            S_SCAN_HI:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{HI_BITS{1'b0}}, hi_reg};
                alu_req.b  = {{HI_BITS{1'b0}}, rd_data_reg};
            end
            S_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(SUM_BITS-COUNT_BITS-1){1'b0}}, div_shift};
                alu_req.b  = {{(SUM_BITS-COUNT_BITS){1'b0}}, held_reg};
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        sample_next = sample_reg;
        pos_next    = pos_reg;
        full_next   = full_reg;
        wpos_next   = wpos_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        cnt_next    = cnt_reg;
        wl_next     = wl_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_duration;
                    pos_next    = start_pos;
                    full_next   = (held_reg >= eff_len);
                    rd_en       = 1'b1;
                    rd_addr     = start_pos;
                    state_next  = S_SUB;
                end
            end
            S_SUB:
            begin
                // drop the oldest sample once the window is full
                if (full_reg)
                begin
                    sum_next = alu_rsp.result;
                end
                wr_en      = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next = alu_rsp.result;
                if (({1'b0, pos_reg} + COUNT_BITS'(1)) >= eff_len)
                begin
                    wpos_next = '0;
                end
                else
                begin
                    wpos_next = pos_reg + ADDR_BITS'(1);
                end
                if (!full_reg)
                begin
                    held_next = held_reg + COUNT_BITS'(1);
                end
                idx_next   = '0;
                lo_next    = '1;
                hi_next    = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_SCAN_LO;
            end
            S_SCAN_LO:
            begin
                if (alu_rsp.borrow)
                begin
                    lo_next = rd_data_reg;
                end
                state_next = S_SCAN_HI;
            end
            S_SCAN_HI:
            begin
                if (alu_rsp.borrow)
                begin
                    hi_next = rd_data_reg;
                end
                if (scan_last)
                begin
                    // upper sum bits stay below the count, so they seed the remainder
                    rem_next   = {{(COUNT_BITS-HI_BITS){1'b0}},
                                  sum_reg[SUM_BITS-1:SAMPLE_BITS]};
                    dq_next    = sum_reg[SAMPLE_BITS-1:0];
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_BITS'(1);
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + ADDR_BITS'(1);
                    state_next = S_SCAN_LO;
                end
            end
            S_DIV:
            begin
                // restoring divide, quotient shifts in where the dividend shifts out
                if (!alu_rsp.borrow)
                begin
                    rem_next = alu_rsp.result[COUNT_BITS-1:0];
                end
                else
                begin
                    rem_next = div_shift[COUNT_BITS-1:0];
                end
                dq_next  = {dq_reg[SAMPLE_BITS-2:0], !alu_rsp.borrow};
                cnt_next = cnt_reg + STEP_BITS'(1);
                if (cnt_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write && paddr[2] == REG_WINDOW_LENGTH)
        begin
            wl_next   = pwdata[COUNT_BITS-1:0];
            wpos_next = '0;
            held_next = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wpos_reg  <= '0;
            held_reg  <= '0;
            sum_reg   <= '0;
            wl_reg    <= WINDOW_RESET;
        end
        else
        begin
            state_reg <= state_next;
            wpos_reg  <= wpos_next;
            held_reg  <= held_next;
            sum_reg   <= sum_next;
            wl_reg    <= wl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        pos_reg    <= pos_next;
        full_reg   <= full_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        cnt_reg    <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[pos_reg] <= sample_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SUB))
        else $error("accepted transaction did not start the update");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_reg != '0) && (held_reg <= eff_len))
        else $error("result with an empty or oversized window");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minimum_duration <= maximum_duration))
        else $error("minimum above maximum");

    a_wpos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ({1'b0, wpos_reg} < eff_len) || (wpos_reg == '0))
        else $error("write position outside the window");
`endif

endmodule

// File: rtl/wss_alu.sv
module wss_alu (
    input  wss_pkg::alu_req_t req,
    output wss_pkg::alu_rsp_t rsp
);
    import wss_pkg::*;

    logic [SUM_BITS:0] wide;

    always_comb
    begin
        if (req.op == ALU_SUB)
        begin
            wide = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            wide = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.result = wide[SUM_BITS-1:0];
        // borrow for subtract, carry for add
        rsp.borrow = wide[SUM_BITS];
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wss_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int CYCLE_LIMIT    = 3000000;
    localparam int SETTLE_CYCLES  = 2 * MAX_DEPTH + 80;
    localparam int REPORT_LINES   = 100;

    localparam logic [PADDR_BITS-1:0] WINDOW_LENGTH_ADDR = PADDR_BITS'(0);
    localparam logic [PADDR_BITS-1:0] UNUSED_REG_ADDR    = PADDR_BITS'(4);

    typedef enum logic [1:0] {MIX_SPREAD, MIX_HIGH, MIX_LOW} sample_mix_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [SAMPLE_BITS-1:0] average;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
    } window_stats_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample_duration = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COUNT_BITS-1:0]  sample_count;
    logic [SAMPLE_BITS-1:0] average_duration;
    logic [SAMPLE_BITS-1:0] minimum_duration;
    logic [SAMPLE_BITS-1:0] maximum_duration;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    window_stats_t          expected_stats[$];

    // shadow of the window state
    logic [SAMPLE_BITS-1:0] held_samples[MAX_DEPTH];
    logic [COUNT_BITS-1:0]  window_setting;
    int unsigned            next_slot;
    int unsigned            samples_held;
    logic [63:0]            window_total;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          sender_gaps_on = 1'b1;
    bit          receiver_stalls_on = 1'b1;

    windowed_sample_statistics uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_duration  (sample_duration),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_count     (sample_count),
        .average_duration (average_duration),
        .minimum_duration (minimum_duration),
        .maximum_duration (maximum_duration),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned effective_window();
        int unsigned len;
        len = 32'(window_setting);
        if (len < 1)
            len = 1;
        if (len > MAX_DEPTH)
            len = MAX_DEPTH;
        return len;
    endfunction

    function automatic void restart_window();
        next_slot    = 0;
        samples_held = 0;
        window_total = '0;
    endfunction

    function automatic window_stats_t add_sample(input logic [SAMPLE_BITS-1:0] value);
        window_stats_t          stats;
        int unsigned            len;
        int unsigned            slot;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        len  = effective_window();
        slot = next_slot;
        if (slot >= len)
            slot = 0;
        // full window: the slot about to be overwritten holds the oldest sample
        if (samples_held >= len)
            window_total -= 64'(held_samples[slot]);
        held_samples[slot] = value;
        window_total += 64'(value);
        next_slot = (slot + 1 >= len) ? 0 : slot + 1;
        if (samples_held < len)
            samples_held++;
        else
            samples_held = len;
        lo = held_samples[0];
        hi = held_samples[0];
        for (int i = 1; i < samples_held; i++)
        begin
            if (held_samples[i] < lo)
                lo = held_samples[i];
            if (held_samples[i] > hi)
                hi = held_samples[i];
        end
        stats.count   = COUNT_BITS'(samples_held);
        stats.average = SAMPLE_BITS'(window_total / 64'(samples_held));
        stats.minimum = lo;
        stats.maximum = hi;
        return stats;
    endfunction

    function automatic int unsigned idle_length(input bit enabled);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_HIGH:
                return (roll < 70) ? '1 : '1 - SAMPLE_BITS'($urandom_range(0, 255));
            MIX_LOW:
                return SAMPLE_BITS'($urandom_range(0, 15));
            default:
            begin
                if (roll < 12)
                    return '0;
                if (roll < 24)
                    return '1;
                if (roll < 34)
                    return SAMPLE_BITS'($urandom_range(0, 1000));
                if (roll < 44)
                    return '1 - SAMPLE_BITS'($urandom_range(0, 1000));
                return SAMPLE_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= REPORT_LINES)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        window_stats_t want;
        if (expected_stats.size() == 0)
        begin
            report_mismatch("result with no transaction outstanding", 64'(sample_count),
                            64'(0));
            return;
        end
        want = expected_stats.pop_front();
        if (sample_count !== want.count)
            report_mismatch("sample_count", 64'(sample_count), 64'(want.count));
        if (average_duration !== want.average)
            report_mismatch("average_duration", 64'(average_duration), 64'(want.average));
        if (minimum_duration !== want.minimum)
            report_mismatch("minimum_duration", 64'(minimum_duration), 64'(want.minimum));
        if (maximum_duration !== want.maximum)
            report_mismatch("maximum_duration", 64'(maximum_duration), 64'(want.maximum));
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            sample_duration <= '0;
            gap_left        <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_stats.push_back(add_sample(sample_duration));
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (sample_queue.size() != 0)
                begin
                    in_valid        <= 1'b1;
                    sample_duration <= sample_queue.pop_front();
                    gap_left        <= idle_length(sender_gaps_on);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= idle_length(receiver_stalls_on);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results outstanding",
                     expected_stats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_BITS-1:0] addr,
                             input logic [PDATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        // register takes the write at this edge
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WINDOW_LENGTH_ADDR)
        begin
            window_setting = data[COUNT_BITS-1:0];
            restart_window();
        end
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_stats.size() != 0);
    endtask

    task automatic queue_samples(input int unsigned n, input sample_mix_t mix);
        @(negedge clk);
        repeat (n)
            sample_queue.push_back(pick_sample(mix));
    endtask

    task automatic queue_fixed(input logic [SAMPLE_BITS-1:0] values[$]);
        @(negedge clk);
        foreach (values[i])
            sample_queue.push_back(values[i]);
    endtask

    initial
    begin
        int unsigned window_plan[7];
        int unsigned random_sent;
        int unsigned phase;
        int unsigned setting;
        int unsigned len;
        int unsigned n;
        sample_mix_t mix;

        window_plan = '{64, 1, 0, 2, 65, 63, 127};
        window_setting = WINDOW_RESET;
        restart_window();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes at the reset window, then tiny and saturated windows
        queue_fixed('{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'hFFFF_FFFE, 32'h0});
        wait_for_drain();
        apb_write(WINDOW_LENGTH_ADDR, 32'd1);
        queue_fixed('{32'hFFFF_FFFF, 32'h0, 32'h1234_5678});
        wait_for_drain();
        // zero length acts as one
        apb_write(WINDOW_LENGTH_ADDR, 32'd0);
        queue_fixed('{32'd9, 32'hFFFF_FFFF});
        wait_for_drain();
        apb_write(WINDOW_LENGTH_ADDR, 32'd2);
        queue_fixed('{32'd5, 32'd7, 32'd1, 32'hFFFF_FFFF});
        wait_for_drain();
        // above the store depth saturates
        apb_write(WINDOW_LENGTH_ADDR, 32'd127);
        queue_fixed('{32'd3, 32'hFFFF_FFFF, 32'h0});
        wait_for_drain();
        // only the low register bits count
        apb_write(WINDOW_LENGTH_ADDR, 32'h0000_0103);
        queue_fixed('{32'd10, 32'd20, 32'd30, 32'd40});
        wait_for_drain();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase < 7)
                setting = window_plan[phase];
            else
                setting = $urandom_range(0, 127);
            apb_write(WINDOW_LENGTH_ADDR, ($urandom & ~32'h7F) | PDATA_BITS'(setting));
            len = effective_window();
            n = $urandom_range(len / 2 + 1, 2 * len + 30);
            if (phase == 0)
            begin
                mix = MIX_HIGH;
                n = 3 * MAX_DEPTH;
            end
            else if ($urandom_range(0, 9) < 7)
                mix = MIX_SPREAD;
            else if ($urandom_range(0, 1) == 0)
                mix = MIX_HIGH;
            else
                mix = MIX_LOW;
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                // hold the sender until the block is empty, then poke a register
                // that does not exist: the window must carry on untouched
                queue_samples(n / 2, mix);
                wait_for_drain();
                apb_write(UNUSED_REG_ADDR, $urandom);
                queue_samples(n - n / 2, mix);
            end
            else
                queue_samples(n, mix);
            random_sent += n;
            phase++;
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_stats.size() != 0)
            report_mismatch("results never produced", 64'(0), 64'(expected_stats.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/wss_pkg.sv
rtl/wss_alu.sv
rtl/windowed_sample_statistics.sv
tb/tb.sv
